[hw/rtl/lcd_8080_window_write_sequencer_core_assert.svh]
// Assertion macros used by the LCD window write sequencer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef LCD_8080_WINDOW_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define LCD_8080_WINDOW_WRITE_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define LWS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcdws assertion failed");
// Clocked check that also holds through reset.
`define LWS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
    else $error("lcdws assertion failed");
`else
`define LWS_ASSERT(name, clk, rst_n, prop)
`define LWS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[hw/rtl/lcdws_pkg.sv]
// Package for the LCD window write sequencer: payload types, codes and
// the window word table. Depends on nothing.
package lcdws_pkg;

    localparam int COORD_BITS = 10;
    localparam int BUS_BITS   = 16;

    // Request queue between the front and the back.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    // Request codes.
    localparam logic [1:0] OP_WINDOW  = 2'd0;
    localparam logic [1:0] OP_PIXEL   = 2'd1;
    localparam logic [1:0] OP_COMMAND = 2'd2;

    // DCS command bytes.
    localparam logic [7:0] DCS_COLUMN_ADDR = 8'h2A;
    localparam logic [7:0] DCS_PAGE_ADDR   = 8'h2B;
    localparam logic [7:0] DCS_MEM_WRITE   = 8'h2C;
    localparam logic [7:0] BYTE_MASK       = 8'hFF;

    // Word positions within a window run.
    localparam logic [3:0] WIN_COL_CMD  = 4'd0;
    localparam logic [3:0] WIN_XS_HI    = 4'd1;
    localparam logic [3:0] WIN_XS_LO    = 4'd2;
    localparam logic [3:0] WIN_XE_HI    = 4'd3;
    localparam logic [3:0] WIN_XE_LO    = 4'd4;
    localparam logic [3:0] WIN_PAGE_CMD = 4'd5;
    localparam logic [3:0] WIN_YS_HI    = 4'd6;
    localparam logic [3:0] WIN_YS_LO    = 4'd7;
    localparam logic [3:0] WIN_YE_HI    = 4'd8;
    localparam logic [3:0] WIN_YE_LO    = 4'd9;
    localparam logic [3:0] WIN_MEM_WR   = 4'd10;

    localparam logic DC_COMMAND = 1'b0;
    localparam logic DC_DATA    = 1'b1;

    typedef struct packed {
        logic [1:0]            op;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [BUS_BITS-1:0]   pixel;
        logic [7:0]            command_code;
        logic                  end_of_burst;
    } t_in;

    typedef struct packed {
        logic                data_command;
        logic [BUS_BITS-1:0] bus_word;
        logic                last;
    } t_out;

    // Classified request held in the queue.
    typedef struct packed {
        logic                  is_window;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] y_end;
        t_out                  word;
    } t_req;

    // Status of the queue head as seen by the back end.
    typedef struct packed {
        logic vld;
        t_req head;
    } t_q_head;

    function automatic logic [7:0] hi_byte(input logic [COORD_BITS-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return w[15:8] & BYTE_MASK;
    endfunction

    function automatic logic [7:0] lo_byte(input logic [COORD_BITS-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return w[7:0] & BYTE_MASK;
    endfunction

    function automatic t_out byte_word(input logic dc, input logic [7:0] b,
                                       input logic last);
        t_out o;
        o.data_command = dc;
        o.bus_word     = BUS_BITS'(b);
        o.last         = last;
        return o;
    endfunction

    // Word at a given position of a window run.
    function automatic t_out window_word(input logic [3:0] step, input t_req r);
        t_out o;
        unique case (step)
            WIN_COL_CMD:  o = byte_word(DC_COMMAND, DCS_COLUMN_ADDR, 1'b0);
            WIN_XS_HI:    o = byte_word(DC_DATA, hi_byte(r.x_start), 1'b0);
            WIN_XS_LO:    o = byte_word(DC_DATA, lo_byte(r.x_start), 1'b0);
            WIN_XE_HI:    o = byte_word(DC_DATA, hi_byte(r.x_end), 1'b0);
            WIN_XE_LO:    o = byte_word(DC_DATA, lo_byte(r.x_end), 1'b0);
            WIN_PAGE_CMD: o = byte_word(DC_COMMAND, DCS_PAGE_ADDR, 1'b0);
            WIN_YS_HI:    o = byte_word(DC_DATA, hi_byte(r.y_start), 1'b0);
            WIN_YS_LO:    o = byte_word(DC_DATA, lo_byte(r.y_start), 1'b0);
            WIN_YE_HI:    o = byte_word(DC_DATA, hi_byte(r.y_end), 1'b0);
            WIN_YE_LO:    o = byte_word(DC_DATA, lo_byte(r.y_end), 1'b0);
            WIN_MEM_WR:   o = byte_word(DC_COMMAND, DCS_MEM_WRITE, 1'b1);
            default:      o = byte_word(DC_COMMAND, DCS_MEM_WRITE, 1'b1);
        endcase
        return o;
    endfunction

endpackage

[hw/rtl/lcd_8080_window_write_sequencer_core.sv]
// An accepted request is written into the request queue, then loaded into the result register.
// Throughput: one result word per cycle while the result register is free or being popped;
// pixel and command requests give one word, a window request gives eleven, set by the back end's word step counter.
// Input is taken while the four-entry request queue has room.
// Reset (synchronous, active low) empties the queue and the result register.
module lcd_8080_window_write_sequencer_core import lcdws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic    q_wr;
    t_req    q_data;
    logic    q_full;
    logic    q_rd;
    t_q_head q_head;

    // Request decode.
    lcdws_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_wr   (q_wr),
        .o_q_data (q_data)
    );

    // Request queue.
    lcdws_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_data),
        .i_rd      (q_rd),
        .o_full    (q_full),
        .o_head    (q_head)
    );

    // Word sequencing and result register.
    lcdws_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q_head),
        .o_q_rd   (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

[hw/rtl/lcdws_front.sv]
// Front end of the LCD window write sequencer: accepts requests, decodes
// the op code and builds queue entries. Depends on lcdws_pkg.
module lcdws_front import lcdws_pkg::*; (
    input  logic i_push,
    input  t_in  i_item,
    input  logic i_q_full,
    output logic o_full,
    output logic o_q_wr,
    output t_req o_q_data
);

    logic accept;

    // A request is taken whenever the queue has room.
    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // Decode the op code; an unused code is taken and dropped.
    always_comb begin
        o_q_wr           = 1'b0;
        o_q_data.is_window = 1'b0;
        o_q_data.x_start = i_item.x_start;
        o_q_data.x_end   = i_item.x_end;
        o_q_data.y_start = i_item.y_start;
        o_q_data.y_end   = i_item.y_end;
        o_q_data.word    = byte_word(DC_COMMAND, i_item.command_code & BYTE_MASK, 1'b1);
        unique case (i_item.op)
            OP_WINDOW: begin
                o_q_wr             = accept;
                o_q_data.is_window = 1'b1;
            end
            OP_PIXEL: begin
                o_q_wr                     = accept;
                o_q_data.word.data_command = DC_DATA;
                o_q_data.word.bus_word     = i_item.pixel;
                o_q_data.word.last         = i_item.end_of_burst;
            end
            OP_COMMAND: begin
                o_q_wr = accept;
            end
            default: begin
                o_q_wr = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/lcdws_queue.sv]
// Short request queue that decouples the front end from the back end.
// Depends on lcdws_pkg.
module lcdws_queue import lcdws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_req    i_wr_data,
    input  logic    i_rd,
    output logic    o_full,
    output t_q_head o_head
);

    t_req                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;
    logic                 do_rd;

    assign o_full      = (r_count == QCNT_BITS'(QDEPTH));
    assign o_head.vld  = (r_count != '0);
    assign o_head.head = r_mem[r_rd_ptr];
    assign do_rd       = i_rd && o_head.vld;

    // Occupancy follows the write and read transfers.
    always_comb begin
        n_count = r_count;
        if (i_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[hw/rtl/lcdws_back.sv]
// Back end of the LCD window write sequencer: steps through queued
// requests and fills the result register. Depends on lcdws_pkg.
`include "lcd_8080_window_write_sequencer_core_assert.svh"
module lcdws_back import lcdws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_q,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_out    o_result
);

    logic [3:0] r_step;
    logic [3:0] n_step;
    logic       r_out_vld;
    t_out       r_out;
    t_out       word;
    logic       adv;
    logic       run_done;

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    // A word moves on when the result register is free or being emptied.
    assign adv      = i_q.vld && (!r_out_vld || i_pop);
    assign run_done = !i_q.head.is_window || (r_step == WIN_MEM_WR);
    assign o_q_rd   = adv && run_done;

    // Pick the word for the current position of the run.
    always_comb begin
        if (i_q.head.is_window) begin
            word = window_word(r_step, i_q.head);
        end else begin
            word = i_q.head.word;
        end
    end

    // Window position counter.
    always_comb begin
        n_step = r_step;
        if (adv && i_q.head.is_window) begin
            n_step = (r_step == WIN_MEM_WR) ? WIN_COL_CMD : r_step + 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= WIN_COL_CMD;
            r_out_vld <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_out_vld <= adv || (r_out_vld && !i_pop);
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= word;
        end
    end

    // The run position never passes the memory-write word.
    `LWS_ASSERT(a_step_range, i_clk, i_rst_n, r_step <= WIN_MEM_WR)
    // A run in progress keeps its window request at the queue head.
    `LWS_ASSERT(a_step_head, i_clk, i_rst_n,
        (r_step != WIN_COL_CMD) |-> (i_q.vld && i_q.head.is_window))
    // The queue is popped only when a word is loaded.
    `LWS_ASSERT(a_pop_adv, i_clk, i_rst_n, o_q_rd |-> adv)
    // After the memory-write word the next run starts from the beginning.
    `LWS_ASSERT(a_wrap, i_clk, i_rst_n,
        (adv && i_q.head.is_window && r_step == WIN_MEM_WR)
        |=> (r_step == WIN_COL_CMD && r_out.last))

endmodule
